// ===== hw/rtl/pcbs_pkg.sv =====
`timescale 1ns / 1ps

package pcbs_pkg;

  localparam int unsigned MaxParticles = 1024;
  localparam int unsigned MaxSide      = 16;
  localparam int unsigned CoordW       = 16;
  localparam int unsigned PidxW        = 10;
  localparam int unsigned CntW         = 11;
  localparam int unsigned CellW        = 12;
  localparam int unsigned CellTotW     = 13;
  localparam int unsigned SideW        = 5;
  localparam int unsigned NcellsMax    = 4096;

  localparam logic [2:0] CmdClear    = 3'd0;
  localparam logic [2:0] CmdInsert   = 3'd1;
  localparam logic [2:0] CmdSort     = 3'd2;
  localparam logic [2:0] CmdReadSlot = 3'd3;
  localparam logic [2:0] CmdReadCell = 3'd4;

  localparam logic [1:0] StOk      = 2'd0;
  localparam logic [1:0] StFull    = 2'd1;
  localparam logic [1:0] StRefused = 2'd2;

  typedef struct packed {
    logic [2:0]        command;
    logic [CoordW-1:0] pos_x;
    logic [CoordW-1:0] pos_y;
    logic [CoordW-1:0] pos_z;
    logic [PidxW-1:0]  slot_index;
    logic [CellW-1:0]  cell_query;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [PidxW-1:0]  particle_index;
    logic [CellW-1:0]  cell_index;
    logic [CoordW-1:0] out_x;
    logic [CoordW-1:0] out_y;
    logic [CoordW-1:0] out_z;
    logic [PidxW-1:0]  original_index;
    logic [CntW-1:0]   cell_start;
    logic [CntW-1:0]   cell_count;
  } out_item_t;

  typedef logic [SideW-1:0] cfg_t;

  function automatic logic [CellTotW-1:0] cell_total(logic [SideW-1:0] n);
    logic [CellTotW-1:0] nn;
    nn = {8'd0, n};
    cell_total = CellTotW'(nn * nn * nn);
  endfunction

endpackage

// ===== hw/rtl/pcbs_chan_if.sv =====
`timescale 1ns / 1ps

interface pcbs_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/particle_cell_binning_sort.sv =====
`timescale 1ns / 1ps
// one command at a time
// clear and every register write run a sweep of all 4096 entries of the cell tables
// sort: per-cell particle link, per-particle move to the other bank, a cell-table sweep,
//   then a per-particle rebin; cell index uses one shared 16x5 multiplier
// reset: asynchronous active low, then a sweep of the cell tables before the first beat
module particle_cell_binning_sort (
  input  logic        clk_i,
  input  logic        rst_ni,
  pcbs_chan_if.sink   in_i,
  pcbs_chan_if.source out_o,
  pcbs_chan_if.sink   cfg_i
);
  import pcbs_pkg::*;

  typedef enum logic [4:0] {
    S_CLR, S_IDLE, S_CALC, S_INS_RD, S_INS_WR,
    S_A_CELL, S_A_GETH, S_A_WALK, S_A_STEP,
    S_B_RD, S_B_WR, S_D_RD, S_D_LAT, S_D_RD2, S_D_WR,
    S_RS_RD, S_RS_LAT, S_RS_FIN, S_RC_RD, S_RC_LAT, S_PUT
  } state_e;

  localparam int unsigned PosW     = PidxW + 3 * CoordW;
  localparam int unsigned ResRestW = $bits(out_item_t) - 2;

  state_e state_q, ret_q, clr_ret_q;
  logic [CellW-1:0]    clr_ptr_q;
  logic [2:0]          cstep_q;
  logic [20:0]         prod_q;
  logic [CellW-1:0]    acc_q;
  logic [4:0]          t_q;
  logic [CoordW-1:0]   x_q, y_q, z_q;
  in_item_t            in_q;
  out_item_t           res_q, out_q;
  logic                ov_q;
  cfg_t                cps_q;
  logic [CellTotW-1:0] ncells_q;
  logic [CntW-1:0]     count_q, i_q, j_q, guard_q;
  logic [CellW-1:0]    c_q;
  logic                sorted_q, bank_q;

  logic [SideW-1:0] n;
  logic [CoordW-1:0] mul_a;
  logic in_fire, out_fire, cfg_fire, put_fire;
  logic [1:0] in_status;

  logic [CntW-1:0] head_mem [NcellsMax];
  logic [CntW-1:0] size_mem [NcellsMax];
  logic [CntW-1:0] next_mem [MaxParticles];
  logic [PosW-1:0] pos0_mem [MaxParticles];
  logic [PosW-1:0] pos1_mem [MaxParticles];

  logic head_we, size_we, next_we, pos_we, pos_wsel;
  logic [CellW-1:0] head_waddr, head_raddr, size_waddr, size_raddr;
  logic [CntW-1:0]  head_wdata, size_wdata, next_wdata;
  logic [PidxW-1:0] next_waddr, next_raddr, pos_waddr, pos_raddr;
  logic [PosW-1:0]  pos_wdata, pos_rd;
  logic [CntW-1:0]  head_rd_q, size_rd_q, next_rd_q;
  logic [PosW-1:0]  pos0_rd_q, pos1_rd_q;
  logic [CntW-1:0]  dest;

  assign n = (cps_q == '0) ? SideW'(1) :
             (cps_q > SideW'(MaxSide)) ? SideW'(MaxSide) : cps_q;

  assign in_i.ready  = (state_q == S_IDLE) && !cfg_i.valid;
  assign cfg_i.ready = 1'b1;
  assign out_o.valid = ov_q;
  assign out_o.data  = out_q;

  assign in_fire  = in_i.valid && in_i.ready;
  assign out_fire = ov_q && out_o.ready;
  assign cfg_fire = cfg_i.valid && cfg_i.ready;
  assign put_fire = (state_q == S_PUT) && (!ov_q || out_o.ready) && !cfg_fire;

  assign pos_rd = bank_q ? pos1_rd_q : pos0_rd_q;
  assign dest   = (next_rd_q >= count_q) ? i_q : next_rd_q;

  always_comb begin
    in_status = StOk;
    unique case (in_i.data.command)
      CmdClear,
      CmdSort:     in_status = StOk;
      CmdInsert: begin
        if (sorted_q) in_status = StRefused;
        else if (count_q >= CntW'(MaxParticles)) in_status = StFull;
      end
      CmdReadSlot: begin
        if (!sorted_q || {1'b0, in_i.data.slot_index} >= count_q) in_status = StRefused;
      end
      CmdReadCell: begin
        if (!sorted_q || {1'b0, in_i.data.cell_query} >= ncells_q) in_status = StRefused;
      end
      default:     in_status = StRefused;
    endcase
  end

  always_comb begin
    unique case (cstep_q)
      3'd0:    mul_a = x_q;
      3'd1:    mul_a = y_q;
      3'd3:    mul_a = z_q;
      3'd2,
      3'd4:    mul_a = {4'd0, acc_q};
      default: mul_a = '0;
    endcase
  end

  // memory port control
  always_comb begin
    head_we = 1'b0; head_waddr = '0; head_wdata = '0; head_raddr = '0;
    size_we = 1'b0; size_waddr = '0; size_wdata = '0; size_raddr = '0;
    next_we = 1'b0; next_waddr = '0; next_wdata = '0; next_raddr = '0;
    pos_we = 1'b0; pos_wsel = bank_q; pos_waddr = '0; pos_wdata = '0; pos_raddr = '0;
    unique case (state_q)
      S_CLR: begin
        head_we = 1'b1; head_waddr = clr_ptr_q; head_wdata = CntW'(MaxParticles);
        size_we = 1'b1; size_waddr = clr_ptr_q; size_wdata = '0;
      end
      S_INS_RD: head_raddr = acc_q;
      S_INS_WR: begin
        next_we = 1'b1; next_waddr = count_q[PidxW-1:0]; next_wdata = head_rd_q;
        head_we = 1'b1; head_waddr = acc_q; head_wdata = count_q;
        pos_we = 1'b1; pos_waddr = count_q[PidxW-1:0];
        pos_wdata = {count_q[PidxW-1:0], x_q, y_q, z_q};
      end
      S_A_CELL: head_raddr = c_q;
      S_A_WALK: next_raddr = i_q[PidxW-1:0];
      S_A_STEP: begin
        next_we = 1'b1; next_waddr = i_q[PidxW-1:0]; next_wdata = j_q;
      end
      S_B_RD: begin
        next_raddr = i_q[PidxW-1:0];
        pos_raddr  = i_q[PidxW-1:0];
      end
      S_B_WR: begin
        pos_we = 1'b1; pos_wsel = ~bank_q; pos_waddr = dest[PidxW-1:0]; pos_wdata = pos_rd;
      end
      S_D_RD:  pos_raddr = i_q[PidxW-1:0];
      S_D_RD2: size_raddr = acc_q;
      S_D_WR: begin
        size_we = 1'b1; size_waddr = acc_q; size_wdata = size_rd_q + CntW'(1);
        if (size_rd_q == '0) begin
          head_we = 1'b1; head_waddr = acc_q; head_wdata = i_q;
        end
      end
      S_RS_RD: pos_raddr = in_q.slot_index;
      S_RC_RD: begin
        head_raddr = in_q.cell_query;
        size_raddr = in_q.cell_query;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (head_we) head_mem[head_waddr] <= head_wdata;
    head_rd_q <= head_mem[head_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (size_we) size_mem[size_waddr] <= size_wdata;
    size_rd_q <= size_mem[size_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (next_we) next_mem[next_waddr] <= next_wdata;
    next_rd_q <= next_mem[next_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (pos_we && !pos_wsel) pos0_mem[pos_waddr] <= pos_wdata;
    pos0_rd_q <= pos0_mem[pos_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (pos_we && pos_wsel) pos1_mem[pos_waddr] <= pos_wdata;
    pos1_rd_q <= pos1_mem[pos_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLR;
      ret_q     <= S_IDLE;
      clr_ret_q <= S_IDLE;
      clr_ptr_q <= '0;
      cstep_q   <= '0;
      prod_q    <= '0;
      acc_q     <= '0;
      t_q       <= '0;
      x_q       <= '0;
      y_q       <= '0;
      z_q       <= '0;
      in_q      <= '0;
      res_q     <= '0;
      out_q     <= '0;
      ov_q      <= 1'b0;
      cps_q     <= SideW'(MaxSide);
      ncells_q  <= '0;
      count_q   <= '0;
      i_q       <= '0;
      j_q       <= '0;
      guard_q   <= '0;
      c_q       <= '0;
      sorted_q  <= 1'b0;
      bank_q    <= 1'b0;
    end else begin
      ncells_q <= cell_total(n);
      if (put_fire) begin
        out_q <= res_q;
        ov_q  <= 1'b1;
      end else if (out_fire) begin
        ov_q <= 1'b0;
      end
      if (cfg_fire) begin
        cps_q     <= cfg_i.data;
        count_q   <= '0;
        sorted_q  <= 1'b0;
        clr_ptr_q <= '0;
        clr_ret_q <= S_IDLE;
        state_q   <= S_CLR;
      end else begin
        unique case (state_q)
          S_IDLE: begin
            if (in_fire) begin
              in_q  <= in_i.data;
              res_q <= {in_status, ResRestW'(0)};
              x_q   <= in_i.data.pos_x;
              y_q   <= in_i.data.pos_y;
              z_q   <= in_i.data.pos_z;
              if (in_status != StOk) begin
                state_q <= S_PUT;
              end else begin
                unique case (in_i.data.command)
                  CmdClear: begin
                    count_q   <= '0;
                    sorted_q  <= 1'b0;
                    clr_ptr_q <= '0;
                    clr_ret_q <= S_PUT;
                    state_q   <= S_CLR;
                  end
                  CmdInsert: begin
                    cstep_q <= '0;
                    ret_q   <= S_INS_RD;
                    state_q <= S_CALC;
                  end
                  CmdSort: begin
                    if (sorted_q) begin
                      state_q <= S_PUT;
                    end else begin
                      c_q     <= '0;
                      j_q     <= '0;
                      state_q <= S_A_CELL;
                    end
                  end
                  CmdReadSlot: state_q <= S_RS_RD;
                  CmdReadCell: state_q <= S_RC_RD;
                  default:     state_q <= S_PUT;
                endcase
              end
            end
          end
          S_CLR: begin
            clr_ptr_q <= clr_ptr_q + CellW'(1);
            i_q       <= '0;
            if (clr_ptr_q == CellW'(NcellsMax - 1)) state_q <= clr_ret_q;
          end
          S_CALC: begin
            prod_q  <= 21'({5'd0, mul_a} * {16'd0, n});
            cstep_q <= cstep_q + 3'd1;
            unique case (cstep_q)
              3'd1:    acc_q <= {7'd0, prod_q[20:16]};
              3'd2,
              3'd4:    t_q <= prod_q[20:16];
              3'd3:    acc_q <= prod_q[CellW-1:0] + {7'd0, t_q};
              3'd5: begin
                acc_q   <= prod_q[CellW-1:0] + {7'd0, t_q};
                state_q <= ret_q;
              end
              default: ;
            endcase
          end
          S_INS_RD: state_q <= S_INS_WR;
          S_INS_WR: begin
            count_q <= count_q + CntW'(1);
            res_q.particle_index <= count_q[PidxW-1:0];
            res_q.cell_index <= acc_q;
            state_q <= S_PUT;
          end
          S_A_CELL: state_q <= S_A_GETH;
          S_A_GETH: begin
            i_q     <= head_rd_q;
            guard_q <= '0;
            state_q <= S_A_WALK;
          end
          S_A_WALK: begin
            if (i_q < count_q && guard_q < count_q) begin
              state_q <= S_A_STEP;
            end else if ({1'b0, c_q} == ncells_q - CellTotW'(1)) begin
              i_q     <= '0;
              state_q <= S_B_RD;
            end else begin
              c_q     <= c_q + CellW'(1);
              state_q <= S_A_CELL;
            end
          end
          S_A_STEP: begin
            i_q     <= next_rd_q;
            j_q     <= j_q + CntW'(1);
            guard_q <= guard_q + CntW'(1);
            state_q <= S_A_WALK;
          end
          S_B_RD: begin
            if (i_q == count_q) begin
              bank_q    <= ~bank_q;
              clr_ptr_q <= '0;
              clr_ret_q <= S_D_RD;
              state_q   <= S_CLR;
            end else begin
              state_q <= S_B_WR;
            end
          end
          S_B_WR: begin
            i_q     <= i_q + CntW'(1);
            state_q <= S_B_RD;
          end
          S_D_RD: begin
            if (i_q == count_q) begin
              sorted_q <= 1'b1;
              state_q  <= S_PUT;
            end else begin
              state_q <= S_D_LAT;
            end
          end
          S_D_LAT: begin
            x_q     <= pos_rd[3*CoordW-1:2*CoordW];
            y_q     <= pos_rd[2*CoordW-1:CoordW];
            z_q     <= pos_rd[CoordW-1:0];
            cstep_q <= '0;
            ret_q   <= S_D_RD2;
            state_q <= S_CALC;
          end
          S_D_RD2: state_q <= S_D_WR;
          S_D_WR: begin
            i_q     <= i_q + CntW'(1);
            state_q <= S_D_RD;
          end
          S_RS_RD: state_q <= S_RS_LAT;
          S_RS_LAT: begin
            x_q <= pos_rd[3*CoordW-1:2*CoordW];
            y_q <= pos_rd[2*CoordW-1:CoordW];
            z_q <= pos_rd[CoordW-1:0];
            res_q.out_x <= pos_rd[3*CoordW-1:2*CoordW];
            res_q.out_y <= pos_rd[2*CoordW-1:CoordW];
            res_q.out_z <= pos_rd[CoordW-1:0];
            res_q.original_index <= pos_rd[PosW-1:3*CoordW];
            cstep_q <= '0;
            ret_q   <= S_RS_FIN;
            state_q <= S_CALC;
          end
          S_RS_FIN: begin
            res_q.cell_index <= acc_q;
            state_q <= S_PUT;
          end
          S_RC_RD: state_q <= S_RC_LAT;
          S_RC_LAT: begin
            res_q.cell_start <= head_rd_q;
            res_q.cell_count <= size_rd_q;
            state_q <= S_PUT;
          end
          S_PUT: begin
            if (put_fire) state_q <= S_IDLE;
          end
          default: state_q <= S_IDLE;
        endcase
      end
    end
  end

  a_busy_after_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !in_i.ready)
    else $error("input taken again before command finished");

  a_cfg_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_fire |=> (state_q == S_CLR) && (count_q == '0) && !sorted_q)
    else $error("register write did not start a table clear");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && out_q.status != StOk) |-> (out_q.particle_index == '0 &&
      out_q.cell_index == '0 && out_q.out_x == '0 && out_q.out_y == '0 &&
      out_q.out_z == '0 && out_q.original_index == '0 &&
      out_q.cell_start == '0 && out_q.cell_count == '0))
    else $error("nonzero fields on failing status");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_INS_WR) |-> (count_q < CntW'(MaxParticles) && !sorted_q))
    else $error("insert write with full or sorted table");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && !out_o.ready) |=> (ov_q && $stable(out_q)))
    else $error("pending result changed");

endmodule
